/* hdl/tced_pkg.sv */
package tced_pkg;

	// Number of floors served by both cars.
	localparam int FLOORS = 8;
	localparam int POS_W  = (FLOORS > 1) ? $clog2(FLOORS) : 1;

	// Fixed widths of the result fields.
	localparam int FLOOR_W = 4;
	localparam int LAMP_W  = 8;
	localparam int PRESS_W = 3;

	typedef logic [FLOORS-1:0] mask_t;
	typedef logic [POS_W-1:0]  pos_t;

	typedef enum logic [1:0] {
		MOT_STILL = 2'd0,
		MOT_UP    = 2'd1,
		MOT_DOWN  = 2'd2
	} motion_t;

	typedef struct packed {
		pos_t    pos;
		motion_t motion;
	} car_t;

	typedef struct packed {
		car_t  left;
		car_t  right;
		mask_t left_calls;
		mask_t right_calls;
		mask_t up_calls;
		mask_t down_calls;
	} state_t;

	typedef struct packed {
		logic               req_type;
		logic               left_press;
		logic [PRESS_W-1:0] left_press_floor;
		logic               right_press;
		logic [PRESS_W-1:0] right_press_floor;
		logic               up_press;
		logic [PRESS_W-1:0] up_press_floor;
		logic               down_press;
		logic [PRESS_W-1:0] down_press_floor;
	} in_item_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] left_floor;
		logic [1:0]         left_direction;
		logic [FLOOR_W-1:0] right_floor;
		logic [1:0]         right_direction;
		logic [LAMP_W-1:0]  left_call_lamps;
		logic [LAMP_W-1:0]  right_call_lamps;
		logic [LAMP_W-1:0]  up_call_lamps;
		logic [LAMP_W-1:0]  down_call_lamps;
	} out_item_t;

	// Any call on a floor above p.
	function automatic logic any_above(mask_t m, pos_t p);
		logic r;
		r = 1'b0;
		for (int i = 0; i < FLOORS; i++) begin
			if (m[i] && (i > int'(p))) r = 1'b1;
		end
		return r;
	endfunction

	// Any call on a floor below p.
	function automatic logic any_below(mask_t m, pos_t p);
		logic r;
		r = 1'b0;
		for (int i = 0; i < FLOORS; i++) begin
			if (m[i] && (i < int'(p))) r = 1'b1;
		end
		return r;
	endfunction

	// Any call on a floor other than p.
	function automatic logic any_other(mask_t m, pos_t p);
		logic r;
		r = 1'b0;
		for (int i = 0; i < FLOORS; i++) begin
			if (m[i] && (i != int'(p))) r = 1'b1;
		end
		return r;
	endfunction

	// Set upward motion and climb one floor, saturating at the top.
	function automatic car_t go_up(car_t c);
		car_t r;
		r = c;
		r.motion = MOT_UP;
		if (int'(c.pos) + 1 < FLOORS) r.pos = c.pos + pos_t'(1);
		return r;
	endfunction

	// Set downward motion and descend one floor, saturating at the bottom.
	function automatic car_t go_down(car_t c);
		car_t r;
		r = c;
		r.motion = MOT_DOWN;
		if (c.pos != '0) r.pos = c.pos - pos_t'(1);
		return r;
	endfunction

endpackage

/* hdl/two_car_elevator_dispatch.sv */
// Two-car elevator dispatcher.
// The input channel (in_valid, in_ready, in_item) carries one transaction per
// button sample or dispatch tick. The output channel (out_valid, out_ready,
// out_item) returns exactly one transaction per input, holding both car
// floors and directions and the four call lamp masks after that input.
// The input register captures a transaction at the edge that accepts it, and the
// result register loads the update when the stage advances, where out_valid rises.
// Throughput is one transaction per cycle while the receiver does not stall, set
// by the single pass through the update logic that also writes car and call state.
// When the receiver stalls, the result register holds its transaction and the
// input register holds the next one; in_ready drops only when both are full.
// Reset puts both cars still at floor one, clears all calls and empties both
// registers.
module two_car_elevator_dispatch
	import tced_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	state_t    state_q;
	state_t    state_d;
	out_item_t res_d;
	logic      adv;
	logic [POS_W:0] lfl;
	logic [POS_W:0] rfl;

	// The stage advances whenever the result register is free or being taken.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	tced_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_d)
	);

	// Pack the next state into a result transaction.
	always_comb begin
		lfl = {1'b0, state_d.left.pos} + (POS_W+1)'(1);
		rfl = {1'b0, state_d.right.pos} + (POS_W+1)'(1);
		res_d.left_floor       = FLOOR_W'(lfl);
		res_d.left_direction   = state_d.left.motion;
		res_d.right_floor      = FLOOR_W'(rfl);
		res_d.right_direction  = state_d.right.motion;
		res_d.left_call_lamps  = LAMP_W'(state_d.left_calls);
		res_d.right_call_lamps = LAMP_W'(state_d.right_calls);
		res_d.up_call_lamps    = LAMP_W'(state_d.up_calls);
		res_d.down_call_lamps  = LAMP_W'(state_d.down_calls);
	end

	// Control and dispatcher state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q.left.pos     <= '0;
			state_q.left.motion  <= MOT_STILL;
			state_q.right.pos    <= '0;
			state_q.right.motion <= MOT_STILL;
			state_q.left_calls   <= '0;
			state_q.right_calls  <= '0;
			state_q.up_calls     <= '0;
			state_q.down_calls   <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) begin
				out_valid_q <= valid_s1;
				if (valid_s1) state_q <= state_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
		if (adv && valid_s1) out_item_q <= res_d;
	end

endmodule

/* hdl/tced_step.sv */
module tced_step
	import tced_pkg::*;
(
	input  state_t   cur,
	input  in_item_t item,
	output state_t   nxt
);

	car_t  l;
	car_t  r;
	mask_t lc;
	mask_t rc;
	mask_t uc;
	mask_t dc;
	mask_t lbit;
	mask_t rbit;

	// Start toward calls of one mask, upward preferred.
	function automatic car_t start_by(mask_t m, car_t c);
		car_t o;
		o = c;
		if (any_other(m, c.pos)) begin
			if (any_above(m, c.pos)) o = go_up(c);
			else if (any_below(m, c.pos)) o = go_down(c);
		end
		return o;
	endfunction

	// Idle car while the other car is moving.
	function automatic car_t idle_single(mask_t own, mask_t up, mask_t dn, car_t c);
		car_t o;
		o = c;
		if (any_other(own, c.pos)) begin
			o = start_by(own, c);
		end else if (any_other(up, c.pos) || any_other(dn, c.pos)) begin
			if (any_above(up, c.pos) || any_above(dn, c.pos)) o = go_up(c);
			else o = go_down(c);
		end
		return o;
	endfunction

	// Moving car keeps direction while calls lie ahead, else reverses or stops.
	function automatic car_t keep_moving(mask_t own, mask_t up, mask_t dn, car_t c);
		car_t o;
		o = c;
		if (c.motion == MOT_UP) begin
			if (any_above(own, c.pos) || any_above(up, c.pos)) o = go_up(c);
			else if (any_below(own, c.pos) || any_below(dn, c.pos)) o = go_down(c);
			else o.motion = MOT_STILL;
		end else begin
			if (any_below(own, c.pos) || any_below(dn, c.pos)) o = go_down(c);
			else if (any_above(own, c.pos) || any_above(up, c.pos)) o = go_up(c);
			else o.motion = MOT_STILL;
		end
		return o;
	endfunction

	always_comb begin
		l  = cur.left;
		r  = cur.right;
		lc = cur.left_calls;
		rc = cur.right_calls;
		uc = cur.up_calls;
		dc = cur.down_calls;
		lbit = '0;
		rbit = '0;

		if (!item.req_type) begin
			// Button sample: latch each press that names a valid floor.
			if (item.left_press && (int'(item.left_press_floor) < FLOORS))
				lc = lc | (mask_t'(1) << item.left_press_floor);
			if (item.right_press && (int'(item.right_press_floor) < FLOORS))
				rc = rc | (mask_t'(1) << item.right_press_floor);
			if (item.up_press && (int'(item.up_press_floor) < FLOORS))
				uc = uc | (mask_t'(1) << item.up_press_floor);
			if (item.down_press && (int'(item.down_press_floor) < FLOORS))
				dc = dc | (mask_t'(1) << item.down_press_floor);
		end else begin
			// Dispatch tick: decide motion of both cars.
			if ((l.motion == MOT_STILL) && (r.motion == MOT_STILL)) begin
				l = start_by(lc, l);
				r = start_by(rc, r);
				if (l.motion == MOT_STILL) begin
					if (any_other(uc, l.pos)) l = start_by(uc, l);
					else l = start_by(dc, l);
				end else if (r.motion == MOT_STILL) begin
					if (any_other(uc, r.pos)) r = start_by(uc, r);
					else r = start_by(dc, r);
				end
			end else begin
				if (l.motion == MOT_STILL) l = idle_single(lc, uc, dc, l);
				else l = keep_moving(lc, uc, dc, l);
				if (r.motion == MOT_STILL) r = idle_single(rc, uc, dc, r);
				else r = keep_moving(rc, uc, dc, r);
			end

			// Clear lamps at the floor reached, left car first.
			lbit = mask_t'(1) << l.pos;
			if (l.motion == MOT_UP) begin
				uc = uc & ~lbit;
				lc = lc & ~lbit;
				if (!any_above(lc, l.pos) && !any_above(uc, l.pos) && !any_above(dc, l.pos))
					dc = dc & ~lbit;
			end else if (l.motion == MOT_DOWN) begin
				dc = dc & ~lbit;
				lc = lc & ~lbit;
				if (!any_below(lc, l.pos) && !any_below(dc, l.pos) && !any_below(uc, l.pos))
					uc = uc & ~lbit;
			end

			rbit = mask_t'(1) << r.pos;
			if (r.motion == MOT_UP) begin
				uc = uc & ~rbit;
				rc = rc & ~rbit;
				if (!any_above(rc, r.pos) && !any_above(uc, r.pos) && !any_above(dc, r.pos))
					dc = dc & ~rbit;
			end else if (r.motion == MOT_DOWN) begin
				dc = dc & ~rbit;
				rc = rc & ~rbit;
				if (!any_below(rc, r.pos) && !any_below(dc, r.pos) && !any_below(uc, r.pos))
					uc = uc & ~rbit;
			end
		end

		nxt.left        = l;
		nxt.right       = r;
		nxt.left_calls  = lc;
		nxt.right_calls = rc;
		nxt.up_calls    = uc;
		nxt.down_calls  = dc;
	end

endmodule
